// ----- rtl/ow_pkg.sv -----
package ow_pkg;

    localparam int FUNC_W     = 2;
    localparam int BYTE_W     = 8;
    localparam int TIME_W     = 10;
    localparam int REL_W      = 8;
    localparam int SAMPLE_W   = 6;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 10;

    // command codes
    localparam logic [FUNC_W-1:0] FUNC_TICK  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_RESET = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_RESET_LOW     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RESET_RELEASE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PRES_WAIT     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PRES_LOW      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_POINT  = 3'd4;

    // register reset values
    localparam logic [TIME_W-1:0]   DEF_RESET_LOW     = 10'd650;
    localparam logic [REL_W-1:0]    DEF_RESET_RELEASE = 8'd10;
    localparam logic [TIME_W-1:0]   DEF_PRES_WAIT     = 10'd120;
    localparam logic [TIME_W-1:0]   DEF_PRES_LOW      = 10'd490;
    localparam logic [SAMPLE_W-1:0] DEF_SAMPLE_POINT  = 6'd9;

    // slot timing in microseconds
    localparam logic [TIME_W-1:0]   WR_LOW_US    = 10'd2;
    localparam logic [TIME_W-1:0]   WR_ZERO_US   = 10'd57;
    localparam logic [TIME_W-1:0]   WR_SLOT_LAST = 10'd61;
    localparam logic [TIME_W-1:0]   RD_LOW_US    = 10'd3;
    localparam logic [SAMPLE_W-1:0] RD_SLOT_LAST = 6'd58;

    localparam logic [BYTE_W-1:0] CRC_POLY_REFL = 8'h8C;

    typedef struct packed {
        logic [TIME_W-1:0]   reset_low_time;
        logic [REL_W-1:0]    reset_release_time;
        logic [TIME_W-1:0]   presence_wait_limit;
        logic [TIME_W-1:0]   presence_low_limit;
        logic [SAMPLE_W-1:0] read_sample_point;
    } t_cfg;

    typedef struct packed {
        logic              drive_low;
        logic              busy_res;
        logic              done_res;
        logic [BYTE_W-1:0] rx_byte;
        logic              presence_fail;
        logic [BYTE_W-1:0] crc_value;
    } t_result;

    // Maxim CRC-8, reflected, one byte
    function automatic logic [BYTE_W-1:0] crc8_update(input logic [BYTE_W-1:0] crc,
                                                      input logic [BYTE_W-1:0] data);
        logic [BYTE_W-1:0] c;
        c = crc ^ data;
        for (int k = 0; k < BYTE_W; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY_REFL;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

// ----- rtl/ow_if.sv -----
interface ow_in_if;
    logic                      valid;
    logic                      ready;
    logic [ow_pkg::FUNC_W-1:0] func;
    logic [ow_pkg::BYTE_W-1:0] tx_byte;
    logic                      line_level;

    modport source (output valid, output func, output tx_byte, output line_level,
                    input ready);
    modport sink   (input valid, input func, input tx_byte, input line_level,
                    output ready);
endinterface

interface ow_out_if;
    logic                      valid;
    logic                      ready;
    logic                      drive_low;
    logic                      busy_res;
    logic                      done_res;
    logic [ow_pkg::BYTE_W-1:0] rx_byte;
    logic                      presence_fail;
    logic [ow_pkg::BYTE_W-1:0] crc_value;

    modport source (output valid, output drive_low, output busy_res, output done_res,
                    output rx_byte, output presence_fail, output crc_value,
                    input ready);
    modport sink   (input valid, input drive_low, input busy_res, input done_res,
                    input rx_byte, input presence_fail, input crc_value,
                    output ready);
endinterface

interface ow_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [ow_pkg::CFG_IDX_W-1:0]  index;
    logic [ow_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- rtl/ow_cfg_regs.sv -----
module ow_cfg_regs (
    input  logic         i_clk,
    input  logic         i_rst_n,
    ow_cfg_if.sink       cfg_ch,
    output ow_pkg::t_cfg o_cfg
);
    import ow_pkg::*;

    t_cfg r_cfg;

    assign cfg_ch.ready = 1'b1;
    assign o_cfg        = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.reset_low_time      <= DEF_RESET_LOW;
            r_cfg.reset_release_time  <= DEF_RESET_RELEASE;
            r_cfg.presence_wait_limit <= DEF_PRES_WAIT;
            r_cfg.presence_low_limit  <= DEF_PRES_LOW;
            r_cfg.read_sample_point   <= DEF_SAMPLE_POINT;
        end else if (cfg_ch.valid) begin
            // keep only the register's width; unknown indexes drop
            unique case (cfg_ch.index)
                REG_RESET_LOW:     r_cfg.reset_low_time      <= cfg_ch.data[TIME_W-1:0];
                REG_RESET_RELEASE: r_cfg.reset_release_time  <= cfg_ch.data[REL_W-1:0];
                REG_PRES_WAIT:     r_cfg.presence_wait_limit <= cfg_ch.data[TIME_W-1:0];
                REG_PRES_LOW:      r_cfg.presence_low_limit  <= cfg_ch.data[TIME_W-1:0];
                REG_SAMPLE_POINT:  r_cfg.read_sample_point   <= cfg_ch.data[SAMPLE_W-1:0];
                default: ;
            endcase
        end
    end

endmodule

// ----- rtl/ow_seq.sv -----
module ow_seq (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  ow_pkg::t_cfg i_cfg,
    ow_in_if.sink        in_ch,
    ow_out_if.source     out_ch
);
    import ow_pkg::*;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_RST_LOW,
        PH_RST_REL,
        PH_WAIT_LOW,
        PH_WAIT_HIGH,
        PH_WRITE,
        PH_READ
    } t_phase;

    t_phase            r_phase,   n_phase;
    logic [TIME_W-1:0] r_time,    n_time;
    logic [2:0]        r_bits,    n_bits;
    logic [BYTE_W-1:0] r_shift,   n_shift;
    logic [BYTE_W-1:0] r_crc,     n_crc;
    logic              r_flag,    n_flag;
    logic [BYTE_W-1:0] r_last_rx, n_last_rx;
    logic              r_out_valid;
    t_result           r_res,     n_res;

    logic                accept;
    logic                drive;
    logic                done;
    logic [TIME_W:0]     time_inc;
    logic [SAMPLE_W-1:0] rd_last;
    logic [BYTE_W-1:0]   rotated;

    assign in_ch.ready = !r_out_valid || out_ch.ready;
    assign accept      = in_ch.valid && in_ch.ready;

    always_comb begin
        n_phase   = r_phase;
        n_time    = r_time;
        n_bits    = r_bits;
        n_shift   = r_shift;
        n_crc     = r_crc;
        n_flag    = r_flag;
        n_last_rx = r_last_rx;
        drive     = 1'b0;
        done      = 1'b0;
        time_inc  = '0;
        rotated   = '0;
        rd_last   = (i_cfg.read_sample_point > RD_SLOT_LAST) ?
                    i_cfg.read_sample_point : RD_SLOT_LAST;

        // start a command on the tick it arrives
        if (r_phase == PH_IDLE && in_ch.func != FUNC_TICK) begin
            n_time = '0;
            n_bits = '0;
            case (in_ch.func)
                FUNC_RESET: begin
                    n_phase = PH_RST_LOW;
                    n_crc   = '0;
                end
                FUNC_WRITE: begin
                    n_phase = PH_WRITE;
                    n_shift = in_ch.tx_byte;
                end
                default: begin
                    n_phase = PH_READ;
                    n_shift = '0;
                end
            endcase
        end

        // zero-length reset parts fall through within the same tick
        if (n_phase == PH_RST_LOW) begin
            if (n_time < i_cfg.reset_low_time) begin
                drive  = 1'b1;
                n_time = n_time + 1'b1;
            end else begin
                n_phase = PH_RST_REL;
                n_time  = '0;
            end
        end

        if (n_phase == PH_RST_REL) begin
            if (n_time < {2'b00, i_cfg.reset_release_time}) begin
                n_time = n_time + 1'b1;
            end else begin
                n_phase = PH_WAIT_LOW;
                n_time  = '0;
            end
        end

        if (n_phase == PH_WAIT_LOW) begin
            if (!in_ch.line_level) begin
                n_phase = PH_WAIT_HIGH;
                n_time  = '0;
            end else begin
                time_inc = {1'b0, n_time} + 1'b1;
                n_time   = time_inc[TIME_W-1:0];
                if (time_inc >= {1'b0, i_cfg.presence_wait_limit}) begin
                    n_flag  = 1'b1;
                    n_phase = PH_IDLE;
                    n_time  = '0;
                    done    = 1'b1;
                end
            end
        end else if (n_phase == PH_WAIT_HIGH) begin
            if (in_ch.line_level) begin
                n_flag  = 1'b0;
                n_phase = PH_IDLE;
                n_time  = '0;
                done    = 1'b1;
            end else begin
                time_inc = {1'b0, n_time} + 1'b1;
                n_time   = time_inc[TIME_W-1:0];
                if (time_inc >= {1'b0, i_cfg.presence_low_limit}) begin
                    n_flag  = 1'b1;
                    n_phase = PH_IDLE;
                    n_time  = '0;
                    done    = 1'b1;
                end
            end
        end else if (n_phase == PH_WRITE) begin
            if (n_time < WR_LOW_US || (!n_shift[0] && n_time < WR_ZERO_US)) begin
                drive = 1'b1;
            end
            if (n_time >= WR_SLOT_LAST) begin
                n_shift = n_shift >> 1;
                n_time  = '0;
                if (n_bits == 3'd7) begin
                    n_bits  = '0;
                    n_phase = PH_IDLE;
                    done    = 1'b1;
                end else begin
                    n_bits = n_bits + 1'b1;
                end
            end else begin
                n_time = n_time + 1'b1;
            end
        end else if (n_phase == PH_READ) begin
            if (n_time < RD_LOW_US) begin
                drive = 1'b1;
            end
            if (n_time == {{(TIME_W-SAMPLE_W){1'b0}}, i_cfg.read_sample_point}) begin
                n_shift[0] = in_ch.line_level;
            end
            rotated = {n_shift[0], n_shift[BYTE_W-1:1]};
            if (n_time >= {{(TIME_W-SAMPLE_W){1'b0}}, rd_last}) begin
                n_time = '0;
                if (n_bits == 3'd7) begin
                    // bits enter at bit 0 and rotate, so the first lands in the LSB
                    n_last_rx = rotated;
                    n_crc     = crc8_update(n_crc, rotated);
                    n_shift   = '0;
                    n_bits    = '0;
                    n_phase   = PH_IDLE;
                    done      = 1'b1;
                end else begin
                    n_shift = {rotated[BYTE_W-1:1], 1'b0};
                    n_bits  = n_bits + 1'b1;
                end
            end else begin
                n_time = n_time + 1'b1;
            end
        end

        n_res.drive_low     = drive;
        n_res.busy_res      = (n_phase != PH_IDLE);
        n_res.done_res      = done;
        n_res.rx_byte       = n_last_rx;
        n_res.presence_fail = n_flag;
        n_res.crc_value     = n_crc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_time      <= '0;
            r_bits      <= '0;
            r_shift     <= '0;
            r_crc       <= '0;
            r_flag      <= 1'b0;
            r_last_rx   <= '0;
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_phase     <= n_phase;
            r_time      <= n_time;
            r_bits      <= n_bits;
            r_shift     <= n_shift;
            r_crc       <= n_crc;
            r_flag      <= n_flag;
            r_last_rx   <= n_last_rx;
            r_res       <= n_res;
            r_out_valid <= 1'b1;
        end else if (out_ch.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign out_ch.valid         = r_out_valid;
    assign out_ch.drive_low     = r_res.drive_low;
    assign out_ch.busy_res      = r_res.busy_res;
    assign out_ch.done_res      = r_res.done_res;
    assign out_ch.rx_byte       = r_res.rx_byte;
    assign out_ch.presence_fail = r_res.presence_fail;
    assign out_ch.crc_value     = r_res.crc_value;

endmodule

// ----- rtl/one_wire_bus_master_top.sv -----
// 1-Wire bus master driven by a stream of microsecond ticks. Every transfer on
// the input channel is one microsecond of bus time and carries a command
// (tick only, reset with presence check, write byte, read byte), the byte to
// write and the sampled bus level; every input transfer yields exactly one
// result transfer with the drive-low request for that microsecond, busy and
// done flags, the last received byte, the presence failure flag and a running
// Maxim CRC-8 over received bytes (cleared by each bus reset). Commands are
// taken only while idle; a command given while busy is ignored. Bytes go LSB
// first with 62 us write slots and read slots of at least 59 us. Rate: one
// item per clock cycle unless the output stalls; each result shows in the
// cycle after its input. The sequencer step sits between the state
// registers and a single result register, and input ready stays high while
// that result register is empty or being drained. Timing registers (reset
// low, release, presence limits, read sample point) use the always-ready
// config channel; the user must write them only while idle (not enforced).
module one_wire_bus_master_top (
    input  logic     i_clk,
    input  logic     i_rst_n,
    ow_cfg_if.sink   i_cfg,
    ow_in_if.sink    i_in,
    ow_out_if.source o_out
);
    import ow_pkg::*;

    t_cfg cfg;

    // hold the timing registers
    ow_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .cfg_ch  (i_cfg),
        .o_cfg   (cfg)
    );

    // advance the bus sequencer once per accepted tick
    ow_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .in_ch   (i_in),
        .out_ch  (o_out)
    );

endmodule

// ----- bench/ow_bus_checker.sv -----
`timescale 1ns / 1ps

module ow_bus_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    ow_cfg_if    i_cfg,
    ow_in_if     i_in,
    ow_out_if    i_out,
    output int   o_fail_count,
    output int   o_pending
);
    import ow_pkg::*;

    // slot timing in microseconds
    localparam int SLOT_WR_LOW   = 2;
    localparam int SLOT_WR_ZERO  = 57;
    localparam int SLOT_WR_LAST  = 61;
    localparam int SLOT_RD_LOW   = 3;
    localparam int SLOT_RD_LAST  = 58;
    localparam int BITS_PER_BYTE = 8;
    localparam int LOOKAHEAD     = 4;
    localparam logic [BYTE_W-1:0] MAXIM_POLY = 8'h8C;

    typedef enum logic [2:0] {
        BUS_IDLE,
        BUS_RST_LOW,
        BUS_RST_REL,
        BUS_WAIT_LOW,
        BUS_WAIT_HIGH,
        BUS_WRITE,
        BUS_READ
    } t_bus_phase;

    // timing registers
    logic [TIME_W-1:0]   rst_low_us;
    logic [REL_W-1:0]    rel_us;
    logic [TIME_W-1:0]   wait_lim;
    logic [TIME_W-1:0]   low_lim;
    logic [SAMPLE_W-1:0] sample_pt;

    // sequencer state
    t_bus_phase          bus_phase;
    logic [TIME_W-1:0]   us_count;
    int                  bits_done;
    logic [BYTE_W-1:0]   shreg;
    logic [BYTE_W-1:0]   crc_acc;
    logic [BYTE_W-1:0]   rx_last;
    logic                pres_fail;

    t_result bus_results_due[$];
    int      mismatches;

    assign o_fail_count = mismatches;

    // shift the byte in bit by bit, low bit first
    function automatic logic [BYTE_W-1:0] maxim_crc_next(input logic [BYTE_W-1:0] crc,
                                                          input logic [BYTE_W-1:0] data);
        logic [BYTE_W-1:0] acc;
        logic              mix;
        acc = crc;
        for (int i = 0; i < BYTE_W; i++) begin
            mix = acc[0] ^ data[i];
            acc = acc >> 1;
            if (mix) begin
                acc = acc ^ MAXIM_POLY;
            end
        end
        return acc;
    endfunction

    // advance the bus by one microsecond, return what the block should show
    function automatic t_result advance_bus_us(input logic [FUNC_W-1:0] func,
                                               input logic [BYTE_W-1:0] tx,
                                               input logic line);
        t_result           res;
        logic              drv;
        logic              fin;
        logic              stop;
        int                tc;
        int                slot_last;
        logic [BYTE_W-1:0] rot;
        drv  = 1'b0;
        fin  = 1'b0;
        stop = 1'b0;
        tc   = int'(us_count);
        if (bus_phase == BUS_IDLE && func != FUNC_TICK) begin
            tc        = 0;
            bits_done = 0;
            case (func)
                FUNC_RESET: begin
                    bus_phase = BUS_RST_LOW;
                    crc_acc   = '0;
                end
                FUNC_WRITE: begin
                    bus_phase = BUS_WRITE;
                    shreg     = tx;
                end
                default: begin
                    bus_phase = BUS_READ;
                    shreg     = '0;
                end
            endcase
        end
        for (int pass = 0; pass < LOOKAHEAD && !stop; pass++) begin
            case (bus_phase)
                BUS_RST_LOW: begin
                    if (tc < rst_low_us) begin
                        drv  = 1'b1;
                        tc   = tc + 1;
                        stop = 1'b1;
                    end else begin
                        bus_phase = BUS_RST_REL;
                        tc        = 0;
                    end
                end
                BUS_RST_REL: begin
                    if (tc < rel_us) begin
                        tc   = tc + 1;
                        stop = 1'b1;
                    end else begin
                        bus_phase = BUS_WAIT_LOW;
                        tc        = 0;
                    end
                end
                BUS_WAIT_LOW: begin
                    stop = 1'b1;
                    if (!line) begin
                        bus_phase = BUS_WAIT_HIGH;
                        tc        = 0;
                    end else begin
                        tc = tc + 1;
                        if (tc >= wait_lim) begin
                            pres_fail = 1'b1;
                            bus_phase = BUS_IDLE;
                            tc        = 0;
                            fin       = 1'b1;
                        end
                    end
                end
                BUS_WAIT_HIGH: begin
                    stop = 1'b1;
                    if (line) begin
                        pres_fail = 1'b0;
                        bus_phase = BUS_IDLE;
                        tc        = 0;
                        fin       = 1'b1;
                    end else begin
                        tc = tc + 1;
                        if (tc >= low_lim) begin
                            pres_fail = 1'b1;
                            bus_phase = BUS_IDLE;
                            tc        = 0;
                            fin       = 1'b1;
                        end
                    end
                end
                BUS_WRITE: begin
                    stop = 1'b1;
                    if (tc < SLOT_WR_LOW || (!shreg[0] && tc < SLOT_WR_ZERO)) begin
                        drv = 1'b1;
                    end
                    if (tc >= SLOT_WR_LAST) begin
                        shreg     = shreg >> 1;
                        tc        = 0;
                        bits_done = bits_done + 1;
                        if (bits_done >= BITS_PER_BYTE) begin
                            bits_done = 0;
                            bus_phase = BUS_IDLE;
                            fin       = 1'b1;
                        end
                    end else begin
                        tc = tc + 1;
                    end
                end
                BUS_READ: begin
                    stop = 1'b1;
                    if (tc < SLOT_RD_LOW) begin
                        drv = 1'b1;
                    end
                    if (tc == sample_pt) begin
                        shreg[0] = line;
                    end
                    slot_last = (sample_pt > SLOT_RD_LAST) ? int'(sample_pt) : SLOT_RD_LAST;
                    if (tc >= slot_last) begin
                        tc        = 0;
                        bits_done = bits_done + 1;
                        // bits land in bit 0; rotate so the first one ends up as the LSB
                        rot = {shreg[0], shreg[BYTE_W-1:1]};
                        if (bits_done >= BITS_PER_BYTE) begin
                            rx_last   = rot;
                            crc_acc   = maxim_crc_next(crc_acc, rot);
                            shreg     = '0;
                            bits_done = 0;
                            bus_phase = BUS_IDLE;
                            fin       = 1'b1;
                        end else begin
                            shreg = {rot[BYTE_W-1:1], 1'b0};
                        end
                    end else begin
                        tc = tc + 1;
                    end
                end
                default: begin
                    stop = 1'b1;
                end
            endcase
        end
        us_count          = tc[TIME_W-1:0];
        res.drive_low     = drv;
        res.busy_res      = (bus_phase != BUS_IDLE);
        res.done_res      = fin;
        res.rx_byte       = rx_last;
        res.presence_fail = pres_fail;
        res.crc_value     = crc_acc;
        return res;
    endfunction

    task automatic check_field(input string name, input logic [BYTE_W-1:0] exp_val,
                               input logic [BYTE_W-1:0] act_val);
        if (act_val !== exp_val) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name,
                     exp_val, act_val);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        t_result exp_res;
        if (!i_rst_n) begin
            rst_low_us = 10'd650;
            rel_us     = 8'd10;
            wait_lim   = 10'd120;
            low_lim    = 10'd490;
            sample_pt  = 6'd9;
            bus_phase  = BUS_IDLE;
            us_count   = '0;
            bits_done  = 0;
            shreg      = '0;
            crc_acc    = '0;
            rx_last    = '0;
            pres_fail  = 1'b0;
            mismatches = 0;
            bus_results_due.delete();
            o_pending <= 0;
        end else begin
            if (i_cfg.valid === 1'b1 && i_cfg.ready === 1'b1) begin
                case (i_cfg.index)
                    REG_RESET_LOW:     rst_low_us = i_cfg.data[TIME_W-1:0];
                    REG_RESET_RELEASE: rel_us     = i_cfg.data[REL_W-1:0];
                    REG_PRES_WAIT:     wait_lim   = i_cfg.data[TIME_W-1:0];
                    REG_PRES_LOW:      low_lim    = i_cfg.data[TIME_W-1:0];
                    REG_SAMPLE_POINT:  sample_pt  = i_cfg.data[SAMPLE_W-1:0];
                    default: ;
                endcase
            end
            if (i_out.valid === 1'b1 && i_out.ready === 1'b1) begin
                if (bus_results_due.size() == 0) begin
                    $display("%0t: result transfer with nothing expected", $time);
                    mismatches++;
                end else begin
                    exp_res = bus_results_due.pop_front();
                    check_field("drive_low", BYTE_W'(exp_res.drive_low),
                                BYTE_W'(i_out.drive_low));
                    check_field("busy_res", BYTE_W'(exp_res.busy_res),
                                BYTE_W'(i_out.busy_res));
                    check_field("done_res", BYTE_W'(exp_res.done_res),
                                BYTE_W'(i_out.done_res));
                    check_field("rx_byte", exp_res.rx_byte, i_out.rx_byte);
                    check_field("presence_fail", BYTE_W'(exp_res.presence_fail),
                                BYTE_W'(i_out.presence_fail));
                    check_field("crc_value", exp_res.crc_value, i_out.crc_value);
                end
            end
            if (i_in.valid === 1'b1 && i_in.ready === 1'b1) begin
                bus_results_due.push_back(advance_bus_us(i_in.func, i_in.tx_byte,
                                                         i_in.line_level));
            end
            o_pending <= bus_results_due.size();
        end
    end

    final begin
        if (bus_results_due.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, bus_results_due.size());
        end
    end

endmodule

// ----- bench/tb_one_wire_bus_master_top.sv -----
`timescale 1ns / 1ps

module tb_one_wire_bus_master_top;
    import ow_pkg::*;

    localparam int  HALF_PERIOD   = 10;
    localparam int  RESET_CYCLES  = 6;
    localparam int  LIMIT_CYCLES  = 900000;
    localparam int  WRITE_SLOT_US = 62;
    localparam int  READ_LAST_US  = 58;
    localparam int  BITS_PER_BYTE = 8;
    localparam int  GAP_PERCENT   = 14;
    localparam int  HOLD_CYCLES   = 80;
    localparam int  TAIL_CYCLES   = 4;
    localparam int  RANDOM_RESETS = 8;

    logic clk;
    logic rst_n;

    ow_cfg_if cfg_ch ();
    ow_in_if  tick_ch ();
    ow_out_if res_ch ();

    int fail_count;
    int pending;

    // stimulus knobs, partly shared with the result-side process, and the watchdog count
    bit gaps_on;
    bit hold_req;
    bit hold_next;
    int cycles;

    // our copy of the timing registers, used only to size the line waveforms
    int rst_low_us;
    int rel_us;
    int wait_lim;
    int low_lim;
    int sample_pt;

    one_wire_bus_master_top u_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_cfg   (cfg_ch.sink),
        .i_in    (tick_ch.sink),
        .o_out   (res_ch.source)
    );

    ow_bus_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg        (cfg_ch),
        .i_in         (tick_ch),
        .i_out        (res_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        clk = 1'b0;
        forever #HALF_PERIOD clk = ~clk;
    end

    // watchdog: give up if the run hangs
    initial begin
        cycles = 0;
        while (cycles < LIMIT_CYCLES) begin
            @(posedge clk);
            cycles++;
        end
        $display("one_wire_bus_master_top verification failed");
        $finish;
    end

    // result side: random back-pressure, plus a long hold-off on request so the
    // result register fills and the block has to stall its input
    initial begin
        int hold_left;
        hold_left    = 0;
        res_ch.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                res_ch.ready = 1'b0;
                hold_left--;
            end else begin
                res_ch.ready = !(gaps_on && $urandom_range(99) < GAP_PERCENT);
            end
        end
    end

    // offer one microsecond to the block; change inputs on the falling edge,
    // return on the rising edge where the transfer happens
    task automatic push_tick(input logic [FUNC_W-1:0] func, input logic [BYTE_W-1:0] tx,
                             input logic lvl);
        @(negedge clk);
        while (gaps_on && $urandom_range(99) < GAP_PERCENT) begin
            tick_ch.valid = 1'b0;
            @(negedge clk);
        end
        tick_ch.valid      = 1'b1;
        tick_ch.func       = func;
        tick_ch.tx_byte    = tx;
        tick_ch.line_level = lvl;
        do @(posedge clk); while (tick_ch.ready !== 1'b1);
    endtask

    // mostly plain ticks while busy, now and then a command that must be ignored
    function automatic logic [FUNC_W-1:0] busy_func();
        logic [FUNC_W-1:0] f;
        f = FUNC_TICK;
        if ($urandom_range(99) < 6) begin
            f = FUNC_W'($urandom_range(3));
        end
        return f;
    endfunction

    // drop valid and hold until every expected result has come back
    task automatic quiesce();
        @(negedge clk);
        tick_ch.valid = 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (2) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        quiesce();
        cfg_ch.valid = 1'b1;
        cfg_ch.index = idx;
        cfg_ch.data  = val;
        do @(posedge clk); while (cfg_ch.ready !== 1'b1);
        @(negedge clk);
        cfg_ch.valid = 1'b0;
        case (idx)
            REG_RESET_LOW:     rst_low_us = int'(val[TIME_W-1:0]);
            REG_RESET_RELEASE: rel_us     = int'(val[REL_W-1:0]);
            REG_PRES_WAIT:     wait_lim   = int'(val[TIME_W-1:0]);
            REG_PRES_LOW:      low_lim    = int'(val[TIME_W-1:0]);
            REG_SAMPLE_POINT:  sample_pt  = int'(val[SAMPLE_W-1:0]);
            default: ;
        endcase
    endtask

    // write all five registers; fill the unused upper data bits with junk
    task automatic set_timing(input logic [TIME_W-1:0] rlt, input logic [REL_W-1:0] rrt,
                              input logic [TIME_W-1:0] wl, input logic [TIME_W-1:0] pl,
                              input logic [SAMPLE_W-1:0] rsp);
        logic [CFG_DATA_W-1:0] junk;
        junk = CFG_DATA_W'($urandom);
        write_reg(REG_RESET_LOW, rlt);
        write_reg(REG_RESET_RELEASE, {junk[CFG_DATA_W-1:REL_W], rrt});
        write_reg(REG_PRES_WAIT, wl);
        write_reg(REG_PRES_LOW, pl);
        write_reg(REG_SAMPLE_POINT, {junk[CFG_DATA_W-1:SAMPLE_W], rsp});
    endtask

    // reset pulse; the slave answers d1 us into the presence window and holds
    // the line low for d2 us (d2 >= 1). Stop on the tick the block finishes.
    task automatic run_reset(input int d1, input int d2);
        int  win;
        int  wl;
        int  pl;
        int  last;
        int  j;
        logic lvl;
        win  = rst_low_us + rel_us;
        wl   = (wait_lim < 1) ? 1 : wait_lim;
        pl   = (low_lim < 1) ? 1 : low_lim;
        last = win + ((d1 >= wl) ? wl - 1 : d1 + ((d2 < pl) ? d2 : pl));
        for (int k = 0; k <= last; k++) begin
            j = k - win;
            if (j < 0) begin
                lvl = 1'($urandom_range(1));
            end else begin
                lvl = !(j >= d1 && j < d1 + d2);
            end
            push_tick((k == 0) ? FUNC_RESET : busy_func(), 8'($urandom_range(255)), lvl);
        end
    endtask

    task automatic run_write(input logic [BYTE_W-1:0] b);
        push_tick(FUNC_WRITE, b, 1'($urandom_range(1)));
        for (int k = 1; k < BITS_PER_BYTE * WRITE_SLOT_US; k++) begin
            push_tick(busy_func(), 8'($urandom_range(255)), 1'($urandom_range(1)));
            if (k == 100 && (hold_next || $urandom_range(7) == 0)) begin
                hold_req  = 1'b1;
                hold_next = 1'b0;
            end
        end
    endtask

    // the slave puts bit i of b on the line at the sample point of slot i;
    // everything else on the line is noise
    task automatic run_read(input logic [BYTE_W-1:0] b);
        int   slot_len;
        int   pos;
        logic lvl;
        slot_len = ((sample_pt > READ_LAST_US) ? sample_pt : READ_LAST_US) + 1;
        for (int k = 0; k < BITS_PER_BYTE * slot_len; k++) begin
            pos = k % slot_len;
            lvl = (pos == sample_pt) ? b[k / slot_len] : 1'($urandom_range(1));
            push_tick((k == 0) ? FUNC_READ : busy_func(), 8'($urandom_range(255)), lvl);
        end
    endtask

    // mostly good presence pulses, some missing ones and some stuck low
    task automatic random_reset();
        int wl;
        int pl;
        int r;
        wl = (wait_lim < 1) ? 1 : wait_lim;
        pl = (low_lim < 1) ? 1 : low_lim;
        r  = $urandom_range(99);
        if (r < 60) begin
            run_reset($urandom_range(0, (wl - 1 < 40) ? wl - 1 : 40),
                      $urandom_range(1, (pl < 80) ? pl : 80));
        end else if (r < 80) begin
            run_reset(wl + $urandom_range(0, 5), 1 + $urandom_range(0, 9));
        end else begin
            run_reset($urandom_range(0, (wl - 1 < 40) ? wl - 1 : 40),
                      pl + $urandom_range(0, 10));
        end
    endtask

    // short values so each reset stays within a few tens of microseconds
    task automatic random_timing();
        set_timing(TIME_W'($urandom_range(0, 12)), REL_W'($urandom_range(0, 8)),
                   TIME_W'($urandom_range(0, 10)), TIME_W'($urandom_range(0, 12)),
                   SAMPLE_W'($urandom_range(0, 63)));
    endtask

    initial begin
        // drive every input to a known value before anything else
        rst_n              = 1'b0;
        cfg_ch.valid       = 1'b0;
        cfg_ch.index       = REG_RESET_LOW;
        cfg_ch.data        = '0;
        tick_ch.valid      = 1'b0;
        tick_ch.func       = FUNC_TICK;
        tick_ch.tx_byte    = '0;
        tick_ch.line_level = 1'b1;
        gaps_on            = 1'b1;
        hold_req           = 1'b0;
        hold_next          = 1'b0;
        rst_low_us         = 650;
        rel_us             = 10;
        wait_lim           = 120;
        low_lim            = 490;
        sample_pt          = 9;

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // short reset timing: good presence, missing presence, stuck low
        set_timing(3, 2, 4, 6, 1);
        run_reset(1, 2);
        run_reset(6, 1);
        run_reset(0, 9);

        // one write with mixed bits; the result side holds off partway through
        hold_next = 1'b1;
        run_write(8'hA5);

        // zero reset times and zero presence limits
        set_timing(0, 0, 0, 0, 1);
        run_reset(0, 3);
        run_reset(5, 1);
        run_reset(0, 1);

        // indexes past the last register must not disturb anything
        for (int idx = int'(REG_SAMPLE_POINT) + 1; idx < (1 << CFG_IDX_W); idx++) begin
            write_reg(CFG_IDX_W'(idx), CFG_DATA_W'($urandom));
        end

        // random short resets with random timing and the odd idle tick
        for (int n = 0; n < RANDOM_RESETS; n++) begin
            if (n % 4 == 0) begin
                random_timing();
            end
            random_reset();
            if ($urandom_range(9) < 3) begin
                repeat ($urandom_range(1, 4)) begin
                    push_tick(FUNC_TICK, 8'($urandom_range(255)), 1'($urandom_range(1)));
                end
            end
            if ($urandom_range(3) == 0) begin
                quiesce();
            end
        end

        // a whole read with no idling on either side; sample inside the low part,
        // junk in the unused upper data bits
        write_reg(REG_SAMPLE_POINT, 10'h3C1);
        gaps_on = 1'b0;
        run_read(8'hC3);
        gaps_on = 1'b1;

        // drain, then let the last registered result settle
        quiesce();
        repeat (TAIL_CYCLES) @(negedge clk);
        if (fail_count == 0) begin
            $display("one_wire_bus_master_top verification clean");
        end else begin
            $display("one_wire_bus_master_top verification failed");
        end
        $finish;
    end

endmodule

// ----- one_wire_bus_master_top.f -----
rtl/ow_pkg.sv
rtl/ow_if.sv
rtl/ow_cfg_regs.sv
rtl/ow_seq.sv
rtl/one_wire_bus_master_top.sv
bench/ow_bus_checker.sv
bench/tb_one_wire_bus_master_top.sv
